[rtl/fdl_pkg.sv]
`default_nettype none

package fdl_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int DELAY_W   = 19;
    localparam int APB_W     = 32;
    localparam int APB_AW    = 3;
    localparam int CMD_DEPTH = 4;
    localparam int OUT_DEPTH = 4;
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // Register byte addresses
    localparam logic [APB_AW-1:0] ADDR_DEFAULT_DELAY = 3'd0;

    typedef enum logic [1:0] {
        ACT_PUSH       = 2'd0,
        ACT_READ_CFG   = 2'd1,
        ACT_READ_GIVEN = 2'd2,
        ACT_CLEAR      = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind                  kind;
        logic signed [SAMPLE_W-1:0] sample;
        logic [DELAY_W-1:0]         delay;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_BOOT  = 2'd0,
        BK_CLEAR = 2'd1,
        BK_RUN   = 2'd2
    } t_back_state;

    typedef struct packed {
        logic boot;
    } t_back_status;

endpackage

`default_nettype wire

[rtl/fdl_fifo.sv]
`default_nettype none

module fdl_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    input  wire logic [WIDTH-1:0]             i_data,
    output logic                              o_full,
    input  wire logic                         i_pop,
    output logic [WIDTH-1:0]                  o_data,
    output logic                              o_empty,
    output logic [$clog2(DEPTH+1)-1:0]        o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

[rtl/fdl_front.sv]
`default_nettype none

module fdl_front #(
    parameter int LINE_LENGTH   = 2048,
    parameter int FRACTION_BITS = 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // item side
    input  wire logic                           push,
    output logic                                full,
    input  wire logic [1:0]                     i_action,
    input  wire logic signed [fdl_pkg::SAMPLE_W-1:0] i_sample_in,
    input  wire logic [fdl_pkg::DELAY_W-1:0]    i_given_delay,
    // configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [fdl_pkg::APB_AW-1:0]     paddr,
    input  wire logic [fdl_pkg::APB_W-1:0]      pwdata,
    output logic [fdl_pkg::APB_W-1:0]           prdata,
    output logic                                pready,
    // command queue
    output logic                                o_cmd_push,
    output fdl_pkg::t_cmd                       o_cmd,
    input  wire logic                           i_cmd_full,
    input  wire fdl_pkg::t_back_status          i_status
);

    import fdl_pkg::*;

    localparam int AW = (LINE_LENGTH > 1) ? $clog2(LINE_LENGTH) : 1;
    localparam int CW = ((AW + FRACTION_BITS > DELAY_W) ? AW + FRACTION_BITS : DELAY_W) + 2;
    localparam logic [CW-1:0] MAX_DELAY = CW'(LINE_LENGTH - 1) << FRACTION_BITS;

    logic [DELAY_W-1:0] r_default_delay, n_default_delay;
    logic [DELAY_W-1:0] wr_delay, given_sat;
    logic               cfg_write;
    t_action            action;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_DEFAULT_DELAY);

    // Clamp to LINE_LENGTH-1 whole samples
    assign wr_delay  = (CW'(pwdata[DELAY_W-1:0]) > MAX_DELAY) ?
                       MAX_DELAY[DELAY_W-1:0] : pwdata[DELAY_W-1:0];
    assign given_sat = (CW'(i_given_delay) > MAX_DELAY) ?
                       MAX_DELAY[DELAY_W-1:0] : i_given_delay;

    assign n_default_delay = cfg_write ? wr_delay : r_default_delay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_delay <= '0;
        end else begin
            r_default_delay <= n_default_delay;
        end
    end

    assign prdata = (paddr == ADDR_DEFAULT_DELAY) ? APB_W'(r_default_delay) : '0;

    // Hold off items while the command queue is full or the post-reset sweep runs
    assign full       = i_cmd_full || i_status.boot;
    assign o_cmd_push = push && !full;
    assign action     = t_action'(i_action);

    always_comb begin
        o_cmd.sample = i_sample_in;
        o_cmd.delay  = r_default_delay;
        o_cmd.kind   = CMD_PUSH;
        case (action)
            ACT_PUSH: begin
                o_cmd.kind = CMD_PUSH;
            end
            ACT_READ_CFG: begin
                o_cmd.kind = CMD_READ;
            end
            ACT_READ_GIVEN: begin
                o_cmd.kind  = CMD_READ;
                o_cmd.delay = given_sat;
            end
            ACT_CLEAR: begin
                o_cmd.kind = CMD_CLEAR;
            end
            default: begin
                o_cmd.kind = CMD_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/fdl_back.sv]
`default_nettype none

module fdl_back #(
    parameter int LINE_LENGTH   = 2048,
    parameter int FRACTION_BITS = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire fdl_pkg::t_cmd                     i_cmd,
    input  wire logic                              i_cmd_valid,
    output logic                                   o_cmd_pop,
    input  wire logic [fdl_pkg::OUT_CNT_W-1:0]     i_out_count,
    output logic                                   o_out_push,
    output logic signed [fdl_pkg::SAMPLE_W-1:0]    o_out_data,
    output fdl_pkg::t_back_status                  o_status
);

    import fdl_pkg::*;

    localparam int FB = FRACTION_BITS;
    localparam int AW = (LINE_LENGTH > 1) ? $clog2(LINE_LENGTH) : 1;
    localparam int CW = ((AW + FB > DELAY_W) ? AW + FB : DELAY_W) + 2;
    localparam int PW = SAMPLE_W + FB + 2;
    localparam logic [AW-1:0] LAST = AW'(LINE_LENGTH - 1);
    localparam logic [CW-1:0] ONE_POS = CW'(1) << FB;
    localparam logic [CW-1:0] WRAP = CW'(LINE_LENGTH) << FB;
    localparam logic [FB:0]   ONE_W = (FB + 1)'(1) << FB;

    t_back_state r_state, n_state;
    logic [AW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_wpos, n_wpos;

    logic [SAMPLE_W-1:0] r_mem [LINE_LENGTH];
    logic                mem_we;
    logic [AW-1:0]       mem_wa;
    logic [SAMPLE_W-1:0] mem_wd;

    logic [CW-1:0] pos_raw, pos;
    logic [AW-1:0] rd_i, rd_j;
    logic [FB-1:0] frac;
    logic          credit_ok, issue;

    logic                       r_v2, r_v3;
    logic [FB-1:0]              r_f2;
    logic signed [SAMPLE_W-1:0] r_rd_a, r_rd_b;
    logic signed [PW-1:0]       r_pa, r_pb;
    logic signed [PW:0]         sum;
    logic signed [PW:0]         shifted;

    // Read position: ((wpos - 1) << FB) - delay, wrapped into the line
    assign pos_raw = (CW'(r_wpos) << FB) - ONE_POS - CW'(i_cmd.delay);
    assign pos     = pos_raw[CW-1] ? pos_raw + WRAP : pos_raw;
    assign rd_i    = pos[FB +: AW];
    assign frac    = pos[FB-1:0];
    assign rd_j    = (rd_i == LAST) ? '0 : rd_i + AW'(1);

    // Keep room in the result queue for every read in flight
    assign credit_ok = ((OUT_CNT_W+1)'(i_out_count) + (OUT_CNT_W+1)'(r_v2)
                        + (OUT_CNT_W+1)'(r_v3)) < (OUT_CNT_W+1)'(OUT_DEPTH);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_wpos    = r_wpos;
        o_cmd_pop = 1'b0;
        mem_we    = 1'b0;
        mem_wa    = r_wpos;
        mem_wd    = i_cmd.sample;
        issue     = 1'b0;
        case (r_state)
            BK_BOOT, BK_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_cnt;
                mem_wd = '0;
                if (r_cnt == LAST) begin
                    n_state = BK_RUN;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end
            BK_RUN: begin
                if (i_cmd_valid) begin
                    case (i_cmd.kind)
                        CMD_PUSH: begin
                            o_cmd_pop = 1'b1;
                            mem_we    = 1'b1;
                            n_wpos    = (r_wpos == LAST) ? '0 : r_wpos + AW'(1);
                        end
                        CMD_READ: begin
                            if (credit_ok) begin
                                o_cmd_pop = 1'b1;
                                issue     = 1'b1;
                            end
                        end
                        CMD_CLEAR: begin
                            o_cmd_pop = 1'b1;
                            n_state   = BK_CLEAR;
                            n_cnt     = '0;
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            default: begin
                n_state = BK_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_BOOT;
            r_cnt   <= '0;
            r_wpos  <= '0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_wpos  <= n_wpos;
            r_v2    <= issue;
            r_v3    <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_a <= r_mem[rd_i];
        r_rd_b <= r_mem[rd_j];
    end

    always_ff @(posedge i_clk) begin
        r_f2 <= frac;
        r_pa <= r_rd_a * $signed({1'b0, ONE_W - {1'b0, r_f2}});
        r_pb <= r_rd_b * $signed({2'b00, r_f2});
    end

    // Floor shift of the weighted sum
    assign sum     = (PW+1)'(r_pa) + (PW+1)'(r_pb);
    assign shifted = sum >>> FB;

    assign o_out_push = r_v3;
    assign o_out_data = shifted[SAMPLE_W-1:0];

    assign o_status.boot = (r_state == BK_BOOT);

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (i_out_count < OUT_CNT_W'(OUT_DEPTH)))
        else $error("result pushed into a full queue");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != BK_RUN) |-> !o_cmd_pop)
        else $error("command taken during a sweep");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wpos <= LAST) && (r_cnt <= LAST))
        else $error("position beyond line length");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_pop && (i_cmd.kind == CMD_CLEAR)) |=> (r_state == BK_CLEAR) && (r_cnt == '0))
        else $error("clear did not start a sweep at entry zero");

endmodule

`default_nettype wire

[rtl/fractional_delay_line.sv]
// A read's result passes from acceptance through the command queue, the registered memory
//   read, the registered products and the result queue before it shows at the output.
// Throughput: one push or read per cycle unless full is high or a read waits for room
//   in the result queue; a clear holds back later items while one store entry per cycle is zeroed.
// Reset (synchronous, active low): queues empty, write position and default delay
//   zero; then a sweep zeroes every store entry with full held high.
`default_nettype none

module fractional_delay_line #(
    parameter int LINE_LENGTH   = 2048,
    parameter int FRACTION_BITS = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic [1:0]                          i_action,
    input  wire logic signed [fdl_pkg::SAMPLE_W-1:0] i_sample_in,
    input  wire logic [fdl_pkg::DELAY_W-1:0]         i_given_delay,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic signed [fdl_pkg::SAMPLE_W-1:0]      o_sample_out,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [fdl_pkg::APB_AW-1:0]          paddr,
    input  wire logic [fdl_pkg::APB_W-1:0]           pwdata,
    output logic [fdl_pkg::APB_W-1:0]                prdata,
    output logic                                     pready
);

    import fdl_pkg::*;

    localparam int CMD_W = $bits(t_cmd);

    logic                      cmd_push, cmd_full, cmd_empty, cmd_pop;
    t_cmd                      cmd_in, cmd_out;
    logic [CMD_W-1:0]          cmd_out_bits;
    logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;
    t_back_status              status;
    logic                      out_push, out_full;
    logic signed [SAMPLE_W-1:0] out_data;
    logic [SAMPLE_W-1:0]       out_bits;
    logic [OUT_CNT_W-1:0]      out_count;

    fdl_front #(
        .LINE_LENGTH   (LINE_LENGTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_action      (i_action),
        .i_sample_in   (i_sample_in),
        .i_given_delay (i_given_delay),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_cmd_push    (cmd_push),
        .o_cmd         (cmd_in),
        .i_cmd_full    (cmd_full),
        .i_status      (status)
    );

    fdl_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out_bits),
        .o_empty (cmd_empty),
        .o_count (cmd_count)
    );

    assign cmd_out = t_cmd'(cmd_out_bits);

    fdl_back #(
        .LINE_LENGTH   (LINE_LENGTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_out),
        .i_cmd_valid (!cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_out_count (out_count),
        .o_out_push  (out_push),
        .o_out_data  (out_data),
        .o_status    (status)
    );

    fdl_fifo #(
        .WIDTH (SAMPLE_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_data),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_bits),
        .o_empty (empty),
        .o_count (out_count)
    );

    assign o_sample_out = out_bits;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_push |-> !out_full)
        else $error("result queue overflow");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.boot |-> (full && (cmd_count == '0)))
        else $error("item taken during the reset sweep");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("command popped from an empty queue");

endmodule

`default_nettype wire
